>>> rtl/topic_multinomial_sampler_core_macros.svh
// assertion macros for the topic sampler core
`ifndef TOPIC_MULTINOMIAL_SAMPLER_CORE_MACROS_SVH
`define TOPIC_MULTINOMIAL_SAMPLER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define TMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked in the cycle after its trigger
`define TMS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/tms_pkg.sv
// shared types, codes and defaults of the topic sampler core
`timescale 1ns / 1ps
`default_nettype none
package tms_pkg;
    localparam int VOCAB_DEF       = 1024;
    localparam int TOPICS_DEF      = 64;
    localparam int DOCS_DEF        = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [6:0] TIU_RESET = 7'd64;
    localparam logic [0:0] ADDR_TIU  = 1'b0;

    localparam logic [2:0] OP_WR_WORD = 3'd0;
    localparam logic [2:0] OP_WR_DOC  = 3'd1;
    localparam logic [2:0] OP_DRAW    = 3'd2;
    localparam logic [2:0] OP_RD_DOC  = 3'd3;
    localparam logic [2:0] OP_RD_WORD = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  word;
        logic [5:0]  topic;
        logic [7:0]  doc;
        logic [15:0] weight;
        logic [15:0] draw;
    } t_item;

    typedef struct packed {
        logic        sat;
        logic [15:0] cnt;
        logic [5:0]  topic;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAC, S_SCALE1, S_SCALE2,
        S_SRCH_RD, S_SRCH_CMP, S_CNT_RD, S_CNT_WR, S_RDD
    } t_state;
endpackage
`default_nettype wire

>>> rtl/tms_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/tms_front.sv
// front end: index reduction and item queue
`timescale 1ns / 1ps
`default_nettype none
module tms_front import tms_pkg::*; #(
    parameter int VOCAB  = VOCAB_DEF,
    parameter int TOPICS = TOPICS_DEF,
    parameter int DOCS   = DOCS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_hold,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  wire logic  i_q_pop
);
    // reciprocal constants: floor(x/n) = (x*m) >> s for every field value
    localparam int SV = 10 + $clog2(VOCAB);
    localparam int ST = 6 + $clog2(TOPICS);
    localparam int SD = 8 + $clog2(DOCS);
    localparam longint unsigned MV = ((64'd1 << SV) + VOCAB - 1) / VOCAB;
    localparam longint unsigned MT = ((64'd1 << ST) + TOPICS - 1) / TOPICS;
    localparam longint unsigned MD = ((64'd1 << SD) + DOCS - 1) / DOCS;
    localparam int PVW = 10 + SV + 1;
    localparam int PTW = 6 + ST + 1;
    localparam int PDW = 8 + SD + 1;
    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_item            r_s1;
    logic             r_s1_v;
    logic [PVW-1:0]   r_pv;
    logic [PTW-1:0]   r_pt;
    logic [PDW-1:0]   r_pd;
    t_item            r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    logic        accept, push;
    logic [31:0] rem_v, rem_t, rem_d, qv, qt, qd;
    t_item       red;

    assign push    = r_s1_v && (32'(r_cnt) < QUEUE_DEPTH);
    assign o_ready = (!r_s1_v || push) && !i_hold;
    assign accept  = i_valid && o_ready;

    always_comb begin
        qv = 32'(r_pv >> SV);
        qt = 32'(r_pt >> ST);
        qd = 32'(r_pd >> SD);
        rem_v = 32'(r_s1.word) - qv * 32'(VOCAB);
        rem_t = 32'(r_s1.topic) - qt * 32'(TOPICS);
        rem_d = 32'(r_s1.doc) - qd * 32'(DOCS);
        if (rem_v >= 32'(VOCAB)) begin
            rem_v = rem_v - 32'(VOCAB);
        end
        if (rem_t >= 32'(TOPICS)) begin
            rem_t = rem_t - 32'(TOPICS);
        end
        if (rem_d >= 32'(DOCS)) begin
            rem_d = rem_d - 32'(DOCS);
        end
        red       = r_s1;
        red.word  = (VOCAB > 1024) ? r_s1.word : 10'(rem_v);
        red.topic = (TOPICS > 64) ? r_s1.topic : 6'(rem_t);
        red.doc   = (DOCS > 256) ? r_s1.doc : 8'(rem_d);
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_s1_v <= accept || (r_s1_v && !push);
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_item;
            r_pv <= PVW'(i_item.word) * PVW'(MV);
            r_pt <= PTW'(i_item.topic) * PTW'(MT);
            r_pd <= PDW'(i_item.doc) * PDW'(MD);
        end
        if (push) begin
            r_mem[r_wp] <= red;
        end
    end
endmodule
`default_nettype wire

>>> rtl/tms_back.sv
// back end: weight tables, accumulate, search, count update, count reads and clear
`timescale 1ns / 1ps
`default_nettype none
`include "topic_multinomial_sampler_core_macros.svh"
module tms_back import tms_pkg::*; #(
    parameter int VOCAB       = VOCAB_DEF,
    parameter int TOPICS      = TOPICS_DEF,
    parameter int DOCS        = DOCS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic [6:0] i_tiu,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    output logic       o_hold,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_res
);
    localparam int WB    = WEIGHT_BITS;
    localparam int CB    = COUNT_BITS;
    localparam int TIW   = $clog2(TOPICS);
    localparam int KW    = $clog2(TOPICS + 1);
    localparam int TW_D  = TOPICS * VOCAB;
    localparam int DT_D  = DOCS * TOPICS;
    localparam int TWA   = $clog2(TW_D);
    localparam int DTA   = $clog2(DT_D);
    localparam int CLR_D = (TW_D > DT_D) ? TW_D : DT_D;
    localparam int CLR_W = $clog2(CLR_D);
    localparam int ACC_W = (2 * WB + KW > 64) ? 64 : 2 * WB + KW;

    function automatic logic [TWA-1:0] tw_addr(input logic [31:0] t, input logic [31:0] w);
        return TWA'(t * 32'(VOCAB) + w);
    endfunction

    function automatic logic [DTA-1:0] dt_addr(input logic [31:0] d, input logic [31:0] t);
        return DTA'(d * 32'(TOPICS) + t);
    endfunction

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [KW-1:0]     r_kt, n_kt, r_k, n_k;
    logic              r_v1, n_v1, r_v2, n_v2;
    logic [TIW-1:0]    r_i1, n_i1, r_i2, n_i2;
    logic [2*WB-1:0]   r_prod, n_prod;
    logic [ACC_W-1:0]  r_sum, n_sum, r_phi, n_phi, r_scaled, n_scaled;
    logic [15:0]       r_plo, n_plo;
    logic [TIW-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic              r_clr_op, n_clr_op;
    logic              r_out_v, n_out_v;
    t_result           r_out, n_out;

    logic             tw_we, dt_we, dc_we, wc_we, cum_we;
    logic [TWA-1:0]   tw_waddr, tw_raddr, wc_waddr, wc_raddr;
    logic [DTA-1:0]   dt_waddr, dt_raddr, dc_waddr, dc_raddr;
    logic [WB-1:0]    wt_wdata, tw_rdata, dt_rdata;
    logic [CB-1:0]    dc_wdata, wc_wdata, dc_rdata, wc_rdata;
    logic [TIW-1:0]   cum_waddr, cum_raddr;
    logic [ACC_W-1:0] cum_wdata, cum_rdata;

    logic [ACC_W:0]   acc;
    logic [ACC_W-1:0] hi_ext, dr_ext;
    logic [31:0]      lo_p;
    logic [TIW:0]     msum;
    logic [8:0]       tiu9;
    logic             dc_sat, wc_sat;

    tms_ram #(.WIDTH(WB), .DEPTH(TW_D)) u_tw (
        .i_clk, .i_we(tw_we), .i_waddr(tw_waddr), .i_wdata(wt_wdata),
        .i_raddr(tw_raddr), .o_rdata(tw_rdata));
    tms_ram #(.WIDTH(WB), .DEPTH(DT_D)) u_dt (
        .i_clk, .i_we(dt_we), .i_waddr(dt_waddr), .i_wdata(wt_wdata),
        .i_raddr(dt_raddr), .o_rdata(dt_rdata));
    tms_ram #(.WIDTH(CB), .DEPTH(DT_D)) u_dc (
        .i_clk, .i_we(dc_we), .i_waddr(dc_waddr), .i_wdata(dc_wdata),
        .i_raddr(dc_raddr), .o_rdata(dc_rdata));
    tms_ram #(.WIDTH(CB), .DEPTH(TW_D)) u_wc (
        .i_clk, .i_we(wc_we), .i_waddr(wc_waddr), .i_wdata(wc_wdata),
        .i_raddr(wc_raddr), .o_rdata(wc_rdata));
    tms_ram #(.WIDTH(ACC_W), .DEPTH(TOPICS)) u_cum (
        .i_clk, .i_we(cum_we), .i_waddr(cum_waddr), .i_wdata(cum_wdata),
        .i_raddr(cum_raddr), .o_rdata(cum_rdata));

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_hold  = (r_state == S_CLEAR) && !r_clr_op;

    always_comb begin
        n_state = r_state;  n_item = r_item;  n_kt = r_kt;  n_k = r_k;
        n_v1 = 1'b0;  n_v2 = 1'b0;  n_i1 = r_i1;  n_i2 = r_i2;
        n_prod = r_prod;  n_sum = r_sum;  n_phi = r_phi;  n_plo = r_plo;
        n_scaled = r_scaled;  n_lo = r_lo;  n_hi = r_hi;  n_mid = r_mid;
        n_clr = r_clr;  n_clr_op = r_clr_op;
        n_out_v = r_out_v && !i_ready;
        n_out = r_out;
        o_q_pop = 1'b0;
        tw_we = 1'b0;  dt_we = 1'b0;  dc_we = 1'b0;  wc_we = 1'b0;  cum_we = 1'b0;
        wt_wdata = WB'(i_q_item.weight);
        tw_waddr = tw_addr(32'(i_q_item.topic), 32'(i_q_item.word));
        dt_waddr = dt_addr(32'(i_q_item.doc), 32'(i_q_item.topic));
        tw_raddr = tw_addr(32'(r_k), 32'(r_item.word));
        dt_raddr = dt_addr(32'(r_item.doc), 32'(r_k));
        dc_raddr = dt_addr(32'(i_q_item.doc), 32'(i_q_item.topic));
        wc_raddr = tw_addr(32'(i_q_item.topic), 32'(i_q_item.word));
        dc_waddr = dt_addr(32'(r_item.doc), 32'(r_lo));
        wc_waddr = tw_addr(32'(r_lo), 32'(r_item.word));
        dc_wdata = '0;  wc_wdata = '0;
        cum_waddr = r_i2;
        msum = {1'b0, r_lo} + {1'b0, r_hi};
        cum_raddr = msum[TIW:1];
        acc = {1'b0, r_sum} + (ACC_W+1)'(r_prod);
        cum_wdata = acc[ACC_W] ? '1 : acc[ACC_W-1:0];
        hi_ext = ACC_W'(r_sum[ACC_W-1:16]);
        dr_ext = ACC_W'(r_item.draw);
        lo_p = 32'(r_sum[15:0]) * 32'(r_item.draw);
        tiu9 = 9'(i_tiu);
        dc_sat = (dc_rdata == '1);
        wc_sat = (wc_rdata == '1);

        unique case (r_state)
            S_CLEAR: begin
                dc_waddr = r_clr[DTA-1:0];
                wc_waddr = r_clr[TWA-1:0];
                dc_we = (32'(r_clr) < DT_D);
                wc_we = (32'(r_clr) < TW_D);
                if (32'(r_clr) == CLR_D - 1) begin
                    n_state = S_IDLE;
                    if (r_clr_op) begin
                        n_out_v = 1'b1;
                        n_out = '0;
                    end
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_v) begin
                    o_q_pop = 1'b1;
                    n_item = i_q_item;
                    n_out = '0;
                    unique case (i_q_item.op)
                        OP_WR_WORD: begin
                            tw_we = 1'b1;
                            n_out_v = 1'b1;
                        end
                        OP_WR_DOC: begin
                            dt_we = 1'b1;
                            n_out_v = 1'b1;
                        end
                        OP_DRAW: begin
                            if (tiu9 == 9'd0) begin
                                n_kt = KW'(1);
                            end else if (32'(tiu9) > TOPICS) begin
                                n_kt = KW'(TOPICS);
                            end else begin
                                n_kt = KW'(tiu9);
                            end
                            n_k = '0;
                            n_sum = '0;
                            n_state = S_MAC;
                        end
                        OP_RD_DOC, OP_RD_WORD: begin
                            n_state = S_RDD;
                        end
                        OP_CLEAR: begin
                            n_clr = '0;
                            n_clr_op = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_out_v = 1'b1;
                        end
                    endcase
                end
            end
            S_MAC: begin
                // read, multiply and accumulate overlap by one topic each
                if (r_k < r_kt) begin
                    n_v1 = 1'b1;
                    n_i1 = r_k[TIW-1:0];
                    n_k = r_k + 1'b1;
                end
                if (r_v1) begin
                    n_prod = (2*WB)'(tw_rdata) * (2*WB)'(dt_rdata);
                    n_v2 = 1'b1;
                    n_i2 = r_i1;
                end
                if (r_v2) begin
                    n_sum = cum_wdata;
                    cum_we = 1'b1;
                end
                if (r_k == r_kt && !r_v1 && !r_v2) begin
                    n_state = S_SCALE1;
                end
            end
            S_SCALE1: begin
                n_phi = hi_ext * dr_ext;
                n_plo = lo_p[31:16];
                n_state = S_SCALE2;
            end
            S_SCALE2: begin
                n_scaled = r_phi + ACC_W'(r_plo);
                n_lo = '0;
                n_hi = TIW'(r_kt - 1'b1);
                n_state = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (r_lo == r_hi) begin
                    n_state = S_CNT_RD;
                end else begin
                    n_mid = msum[TIW:1];
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                // lowest topic whose running sum reaches the scaled draw
                if (cum_rdata >= r_scaled) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
                n_state = S_SRCH_RD;
            end
            S_CNT_RD: begin
                dc_raddr = dt_addr(32'(r_item.doc), 32'(r_lo));
                wc_raddr = tw_addr(32'(r_lo), 32'(r_item.word));
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                dc_wdata = dc_sat ? dc_rdata : dc_rdata + 1'b1;
                wc_wdata = wc_sat ? wc_rdata : wc_rdata + 1'b1;
                dc_we = 1'b1;
                wc_we = 1'b1;
                n_out.topic = 6'(r_lo);
                n_out.cnt = 16'(dc_wdata);
                n_out.sat = dc_sat || wc_sat;
                n_out_v = 1'b1;
                n_state = S_IDLE;
            end
            S_RDD: begin
                n_out.cnt = (r_item.op == OP_RD_DOC) ? 16'(dc_rdata) : 16'(wc_rdata);
                n_out_v = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_clr_op <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_clr_op <= n_clr_op;
            r_v1     <= n_v1;
            r_v2     <= n_v2;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;  r_kt <= n_kt;  r_k <= n_k;
        r_i1 <= n_i1;  r_i2 <= n_i2;  r_prod <= n_prod;  r_sum <= n_sum;
        r_phi <= n_phi;  r_plo <= n_plo;  r_scaled <= n_scaled;
        r_lo <= n_lo;  r_hi <= n_hi;  r_mid <= n_mid;  r_out <= n_out;
    end

    `TMS_ASSERT(a_pop_out_free, o_q_pop |-> !r_out_v, "item taken while result pending")
    `TMS_ASSERT(a_srch_order, (r_state == S_SRCH_CMP) |-> (r_lo < r_hi), "search bounds crossed")
    `TMS_ASSERT(a_pick_range, (r_state == S_CNT_RD) |-> (KW'(r_lo) < r_kt), "pick beyond topics")
    `TMS_ASSERT_NEXT(a_init_no_pop, o_hold, !o_q_pop || o_hold, "item taken during init")
endmodule
`default_nettype wire

>>> rtl/topic_multinomial_sampler_core.sv
// Topic multinomial sampler core.
// Input beats on s_axis: tuser carries the op, tdata the word, topic, doc,
// weight and draw fields. Every beat returns one result beat on m_axis
// (chosen topic, count value, saturation flag). topics_in_use sits at APB
// address 0, to be written only while the block is idle; no check enforces it.
// Items run one at a time in the back end; a four-entry queue after the
// index reduction stage lets the input side keep accepting meanwhile.
// A draw for kt active topics runs the shared multiply-accumulate, which
// walks the topics one per cycle through the weight ram read ports, then
// the binary search on the running-sum ram and the read-modify-write of
// both count rams.
// A clear counts op sweeps both count rams. After reset the same sweep
// runs with s_axis_tready low; APB writes are taken throughout.
// A result waits in the output register while m_axis_tready is low; the
// back end takes no new item until it has gone.
`timescale 1ns / 1ps
`default_nettype none
module topic_multinomial_sampler_core import tms_pkg::*; #(
    parameter int VOCAB       = VOCAB_DEF,
    parameter int TOPICS      = TOPICS_DEF,
    parameter int DOCS        = DOCS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // word[9:0], topic[15:10], doc[23:16], weight[39:24], draw[55:40]
    input  wire logic [55:0] s_axis_tdata,
    // op[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // chosen_topic[5:0], count_value[21:6], count_saturated[22], zero[23]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [6:0] r_tiu;
    t_item      in_item, q_item;
    t_result    res;
    logic       q_valid, q_pop, hold;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIU) ? 32'(r_tiu) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu <= TIU_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TIU) begin
            r_tiu <= pwdata[6:0];
        end
    end

    assign in_item.op     = s_axis_tuser;
    assign in_item.word   = s_axis_tdata[9:0];
    assign in_item.topic  = s_axis_tdata[15:10];
    assign in_item.doc    = s_axis_tdata[23:16];
    assign in_item.weight = s_axis_tdata[39:24];
    assign in_item.draw   = s_axis_tdata[55:40];

    tms_front #(.VOCAB(VOCAB), .TOPICS(TOPICS), .DOCS(DOCS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .i_hold(hold), .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop));

    tms_back #(
        .VOCAB(VOCAB), .TOPICS(TOPICS), .DOCS(DOCS),
        .WEIGHT_BITS(WEIGHT_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_tiu(r_tiu),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop), .o_hold(hold),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    assign m_axis_tdata = {1'b0, res.sat, res.cnt, res.topic};
endmodule
`default_nettype wire
